// ===== rtl/fwfc_pkg.sv =====
// Shared types and constants of the filament width flow compensator.
package fwfc_pkg;

  localparam int WIDTH_W = 9;
  localparam int POS_W = 40;
  localparam int TARGET_W = 41;
  localparam int FLOW_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int DELAY_W = 32;

  localparam logic [WIDTH_W-1:0] NOMINAL_RESET = 9'd100;
  localparam logic [WIDTH_W-1:0] NO_FIL_LIMIT = 9'd50;
  localparam int FULL_SCALE = 500;
  localparam int FLOW_SCALE = 100;
  localparam logic [FLOW_W-1:0] NEUTRAL_FLOW = 16'd100;

  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd3;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_TICK = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CAUSE_MEASURED = 2'd0,
    CAUSE_RANGE = 2'd1,
    CAUSE_NO_FIL = 2'd2,
    CAUSE_CLEARED = 2'd3
  } cause_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMUL,
    ST_PUSH,
    ST_READ,
    ST_CHECK,
    ST_SQUARE,
    ST_SCALE,
    ST_DIV,
    ST_FINISH,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0] action;
    logic [11:0] adc_code;
    logic signed [POS_W-1:0] extruder_position;
  } in_item_t;

  typedef struct packed {
    logic [FLOW_W-1:0] flow_percent;
    logic [1:0] cause;
    logic queue_overflow;
  } out_item_t;

  typedef struct packed {
    logic signed [TARGET_W-1:0] position;
    logic [WIDTH_W-1:0] width;
  } entry_t;

endpackage

// ===== rtl/filament_width_flow_compensator.sv =====
// Top level of the filament width flow compensator core.
//
// The core converts sensor samples to a filament width, queues that width in a
// RAM at the extruder position where the filament will reach the nozzle, and on
// each tick pops the due entry and returns a flow percentage. One item is worked
// on at a time and in_ready_o is high only while the core waits for an item; a
// finished result sits in an output register, so the next input transfer can be
// taken while that result still waits. A tick that yields a measured flow goes
// through the bit-serial divider, which produces one quotient bit per cycle. A
// sample's width is scaled by a multiply with a constant reciprocal. A clear
// goes straight to the output, and a disabled tick or an unused action yields
// no result. A result that finds the output register still occupied holds the
// core until that register drains. The queue RAM is read in the cycle after the
// push is written, so a tick never sees stale data. The RAM needs no clearing
// pass after reset.
module filament_width_flow_compensator_core #(
  parameter int QUEUE_DEPTH = 64,
  parameter int ADC_BITS = 12,
  parameter int INTERVAL_UM = 10000
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  fwfc_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output fwfc_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [fwfc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fwfc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int NUM_W = (ADC_BITS + 9 > 25) ? ADC_BITS + 9 : 25;
  localparam int DEN_W = (ADC_BITS > 18) ? ADC_BITS : 18;
  localparam int FULL = (1 << ADC_BITS) - 1;
  localparam int HALF = FULL / 2;
  localparam int WW = fwfc_pkg::WIDTH_W;
  localparam int SQ_W = 2 * fwfc_pkg::WIDTH_W;
  localparam int RECIP_SH = NUM_W + ADC_BITS;
  localparam int RECIP_W = NUM_W + 1;
  localparam int PROD_W = NUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((longint'(1) << RECIP_SH) + longint'(FULL) - longint'(1)) / longint'(FULL));

  fwfc_pkg::state_e state_q, state_d;

  logic [WW-1:0]                      nom_q, nom_d;
  logic [WW-1:0]                      diff_q, diff_d;
  logic [fwfc_pkg::DELAY_W-1:0]       delay_q, delay_d;
  logic                               en_q, en_d;
  logic [WW-1:0]                      last_width_q, last_width_d;
  logic [IDX_W-1:0]                   head_q, head_d;
  logic [IDX_W-1:0]                   tail_q, tail_d;
  logic [CNT_W-1:0]                   count_q, count_d;
  logic                               ovf_q, ovf_d;
  logic                               out_valid_q, out_valid_d;
  fwfc_pkg::out_item_t                out_q, out_d;

  logic signed [fwfc_pkg::TARGET_W-1:0] newest_q, newest_d;
  logic signed [fwfc_pkg::TARGET_W-1:0] target_q, target_d;
  logic signed [fwfc_pkg::POS_W-1:0]    pos_q, pos_d;
  logic [1:0]                         act_q, act_d;
  logic [ADC_BITS-1:0]                code_q, code_d;
  logic [NUM_W-1:0]                   samp_q, samp_d;
  logic [WW-1:0]                      w_q, w_d;
  logic [SQ_W-1:0]                    sqn_q, sqn_d;
  logic [SQ_W-1:0]                    sqw_q, sqw_d;
  logic [fwfc_pkg::FLOW_W-1:0]        flow_q, flow_d;
  fwfc_pkg::cause_e                   cause_q, cause_d;

  logic                  ram_we;
  logic                  ram_re;
  fwfc_pkg::entry_t      ram_wdata;
  fwfc_pkg::entry_t      rd_entry;

  logic                  div_start;
  logic                  div_busy;
  logic [NUM_W-1:0]      div_num;
  logic [DEN_W-1:0]      div_den;
  logic [NUM_W-1:0]      div_quo;
  logic [PROD_W-1:0]     recip_prod;

  logic signed [fwfc_pkg::TARGET_W:0]   target_ext;
  logic signed [fwfc_pkg::TARGET_W:0]   newest_ext;
  logic signed [fwfc_pkg::TARGET_W:0]   limit;
  logic signed [fwfc_pkg::TARGET_W-1:0] pos_ext;
  logic signed [fwfc_pkg::TARGET_W-1:0] head_pos;
  logic signed [WW+1:0]                 lo_bound;
  logic signed [WW+1:0]                 hi_bound;
  logic signed [WW+1:0]                 w_ext;
  logic                                 do_push;
  logic                                 queue_full;
  logic                                 wide_enough;
  logic                                 due;
  logic                                 in_range;
  logic                                 out_free;
  logic [IDX_W-1:0]                     head_next;
  logic [IDX_W-1:0]                     tail_next;

  assign target_ext = {target_q[fwfc_pkg::TARGET_W-1], target_q};
  assign newest_ext = {newest_q[fwfc_pkg::TARGET_W-1], newest_q};
  assign limit = newest_ext + $signed((fwfc_pkg::TARGET_W + 1)'(INTERVAL_UM));
  assign do_push = (count_q == '0) || (target_ext >= limit);
  assign queue_full = count_q == CNT_W'(QUEUE_DEPTH);
  assign wide_enough = last_width_q > fwfc_pkg::NO_FIL_LIMIT;

  assign pos_ext = {pos_q[fwfc_pkg::POS_W-1], pos_q};
  assign head_pos = rd_entry.position;
  assign due = (count_q != '0) && !(head_pos > pos_ext);

  assign lo_bound = $signed({2'b00, nom_q}) - $signed({2'b00, diff_q});
  assign hi_bound = $signed({2'b00, nom_q}) + $signed({2'b00, diff_q});
  assign w_ext = {2'b00, rd_entry.width};
  assign in_range = (rd_entry.width != '0) && (w_ext >= lo_bound) && (w_ext <= hi_bound);

  assign out_free = !out_valid_q || out_ready_i;
  assign head_next = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
  assign tail_next = (tail_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + IDX_W'(1);

  assign recip_prod = PROD_W'(samp_q) * PROD_W'(RECIP);

  always_comb begin
    state_d = state_q;
    case (state_q)
      fwfc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.action)
            fwfc_pkg::ACT_SAMPLE: state_d = fwfc_pkg::ST_SMUL;
            fwfc_pkg::ACT_CLEAR: state_d = fwfc_pkg::ST_EMIT;
            fwfc_pkg::ACT_TICK: state_d = en_q ? fwfc_pkg::ST_PUSH : fwfc_pkg::ST_IDLE;
            default: state_d = fwfc_pkg::ST_IDLE;
          endcase
        end
      end
      fwfc_pkg::ST_SMUL: state_d = fwfc_pkg::ST_FINISH;
      fwfc_pkg::ST_PUSH: state_d = wide_enough ? fwfc_pkg::ST_READ : fwfc_pkg::ST_EMIT;
      fwfc_pkg::ST_READ: state_d = fwfc_pkg::ST_CHECK;
      fwfc_pkg::ST_CHECK: begin
        if (!due) begin
          state_d = fwfc_pkg::ST_IDLE;
        end else if (in_range) begin
          state_d = fwfc_pkg::ST_SQUARE;
        end else begin
          state_d = fwfc_pkg::ST_EMIT;
        end
      end
      fwfc_pkg::ST_SQUARE: state_d = fwfc_pkg::ST_SCALE;
      fwfc_pkg::ST_SCALE: state_d = fwfc_pkg::ST_DIV;
      fwfc_pkg::ST_DIV: begin
        if (!div_busy) begin
          state_d = fwfc_pkg::ST_FINISH;
        end
      end
      fwfc_pkg::ST_FINISH: begin
        state_d = (act_q == fwfc_pkg::ACT_SAMPLE) ? fwfc_pkg::ST_IDLE : fwfc_pkg::ST_EMIT;
      end
      fwfc_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = fwfc_pkg::ST_IDLE;
        end
      end
      default: state_d = fwfc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    nom_d = nom_q;
    diff_d = diff_q;
    delay_d = delay_q;
    en_d = en_q;
    last_width_d = last_width_q;
    head_d = head_q;
    tail_d = tail_q;
    count_d = count_q;
    ovf_d = ovf_q;
    newest_d = newest_q;
    target_d = target_q;
    pos_d = pos_q;
    act_d = act_q;
    code_d = code_q;
    samp_d = samp_q;
    w_d = w_q;
    sqn_d = sqn_q;
    sqw_d = sqw_q;
    flow_d = flow_q;
    cause_d = cause_q;
    out_d = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we = 1'b0;
    ram_re = 1'b0;
    ram_wdata = '{position: target_q, width: last_width_q};
    div_start = 1'b0;
    div_num = NUM_W'(sqn_q) * NUM_W'(fwfc_pkg::FLOW_SCALE) + NUM_W'(sqw_q >> 1);
    div_den = DEN_W'(sqw_q);

    if (cfg_we_i) begin
      case (cfg_index_i)
        fwfc_pkg::REG_NOMINAL: nom_d = cfg_wdata_i[WW-1:0];
        fwfc_pkg::REG_MAX_DIFF: diff_d = cfg_wdata_i[WW-1:0];
        fwfc_pkg::REG_DELAY: delay_d = cfg_wdata_i[fwfc_pkg::DELAY_W-1:0];
        fwfc_pkg::REG_ENABLE: begin
          en_d = cfg_wdata_i[0];
          if (en_q && !cfg_wdata_i[0]) begin
            head_d = '0;
            tail_d = '0;
            count_d = '0;
          end
        end
        default: ;
      endcase
    end

    case (state_q)
      fwfc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          act_d = in_data_i.action;
          code_d = ADC_BITS'(in_data_i.adc_code);
          pos_d = in_data_i.extruder_position;
          target_d = $signed({in_data_i.extruder_position[fwfc_pkg::POS_W-1],
                              in_data_i.extruder_position})
                   + $signed({9'd0, delay_q});
          if (in_data_i.action == fwfc_pkg::ACT_CLEAR) begin
            head_d = '0;
            tail_d = '0;
            count_d = '0;
            flow_d = fwfc_pkg::NEUTRAL_FLOW;
            cause_d = fwfc_pkg::CAUSE_CLEARED;
          end
        end
      end
      fwfc_pkg::ST_SMUL: begin
        samp_d = NUM_W'(code_q) * NUM_W'(fwfc_pkg::FULL_SCALE) + NUM_W'(HALF);
      end
      fwfc_pkg::ST_PUSH: begin
        if (do_push) begin
          if (queue_full) begin
            ovf_d = 1'b1;
          end else if (wide_enough) begin
            ram_we = 1'b1;
            newest_d = target_q;
            tail_d = tail_next;
            count_d = count_q + CNT_W'(1);
          end
        end
        if (!wide_enough) begin
          head_d = '0;
          tail_d = '0;
          count_d = '0;
          flow_d = fwfc_pkg::NEUTRAL_FLOW;
          cause_d = fwfc_pkg::CAUSE_NO_FIL;
        end
      end
      fwfc_pkg::ST_READ: begin
        ram_re = 1'b1;
      end
      fwfc_pkg::ST_CHECK: begin
        if (due) begin
          head_d = head_next;
          count_d = count_q - CNT_W'(1);
          w_d = rd_entry.width;
          flow_d = fwfc_pkg::NEUTRAL_FLOW;
          cause_d = fwfc_pkg::CAUSE_RANGE;
        end
      end
      fwfc_pkg::ST_SQUARE: begin
        sqn_d = SQ_W'(nom_q) * SQ_W'(nom_q);
        sqw_d = SQ_W'(w_q) * SQ_W'(w_q);
      end
      fwfc_pkg::ST_SCALE: begin
        div_start = 1'b1;
      end
      fwfc_pkg::ST_FINISH: begin
        if (act_q == fwfc_pkg::ACT_SAMPLE) begin
          last_width_d = recip_prod[RECIP_SH +: WW];
        end else begin
          flow_d = (|div_quo[NUM_W-1:fwfc_pkg::FLOW_W]) ? '1 : div_quo[fwfc_pkg::FLOW_W-1:0];
          cause_d = fwfc_pkg::CAUSE_MEASURED;
        end
      end
      fwfc_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{flow_percent: flow_q, cause: cause_q, queue_overflow: ovf_q};
          ovf_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fwfc_pkg::ST_IDLE;
      nom_q <= fwfc_pkg::NOMINAL_RESET;
      diff_q <= '0;
      delay_q <= '0;
      en_q <= 1'b1;
      last_width_q <= '0;
      head_q <= '0;
      tail_q <= '0;
      count_q <= '0;
      ovf_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      nom_q <= nom_d;
      diff_q <= diff_d;
      delay_q <= delay_d;
      en_q <= en_d;
      last_width_q <= last_width_d;
      head_q <= head_d;
      tail_q <= tail_d;
      count_q <= count_d;
      ovf_q <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    newest_q <= newest_d;
    target_q <= target_d;
    pos_q <= pos_d;
    act_q <= act_d;
    code_q <= code_d;
    samp_q <= samp_d;
    w_q <= w_d;
    sqn_q <= sqn_d;
    sqw_q <= sqw_d;
    flow_q <= flow_d;
    cause_q <= cause_d;
    out_q <= out_d;
  end

  fwfc_ram #(
    .WIDTH($bits(fwfc_pkg::entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (rd_entry)
  );

  fwfc_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  assign in_ready_o = state_q == fwfc_pkg::ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("Queue count exceeds the queue depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q))
    else $error("Empty queue with head and tail apart.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (count_q < CNT_W'(QUEUE_DEPTH)))
    else $error("Queue RAM written while the queue is full.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fwfc_pkg::ST_EMIT && out_valid_q && !out_ready_i)
      |=> (state_q == fwfc_pkg::ST_EMIT))
    else $error("Result left the emit state while the output register was occupied.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_width_q <= WW'(fwfc_pkg::FULL_SCALE))
    else $error("Filament width beyond full scale.");

endmodule

// ===== rtl/fwfc_ram.sv =====
// Generic single-port-write, registered-read RAM.
module fwfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fwfc_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module fwfc_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign fits = shifted >= {1'b0, den_q};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
      cnt_d = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quo_o = quo_q;

endmodule

// ===== dv/filament_width_flow_compensator_core_tb.sv =====
// Self-checking testbench for the filament width flow compensator core.
module filament_width_flow_compensator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fwfc_pkg::*;

  localparam int QDEPTH = 64;
  localparam int ADC_BITS = 12;
  localparam int INTERVAL_UM = 10000;
  localparam longint ADC_FULL = (64'd1 << ADC_BITS) - 1;
  localparam longint FLOW_MAX = 65535;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int IDLE_PCT = 18;
  localparam int REPORT_LIMIT = 100;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    in_item_t item;
    bit fixed;
    out_item_t fixed_res;
  } step_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  logic [WIDTH_W-1:0] nom_w;
  logic [WIDTH_W-1:0] tol_w;
  logic [DELAY_W-1:0] lag_um;
  logic ticks_on;
  logic [WIDTH_W-1:0] width_now;
  longint slot_pos[QDEPTH];
  int slot_width[QDEPTH];
  int rd_ptr;
  int wr_ptr;
  int fill;
  bit dropped_push;

  out_item_t pending_flows[$];
  step_t directed[$];
  out_item_t want;
  int errors = 0;
  int stall_cycles = 0;
  bit steady = 1'b0;
  bit orderly = 1'b0;
  bit hold_req = 1'b0;
  longint cur_pos;
  int step_lo;
  int step_hi;

  filament_width_flow_compensator_core #(
    .QUEUE_DEPTH(QDEPTH),
    .ADC_BITS(ADC_BITS),
    .INTERVAL_UM(INTERVAL_UM)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void flush_queue();
    rd_ptr = 0;
    wr_ptr = 0;
    fill = 0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_NOMINAL: nom_w = val[WIDTH_W-1:0];
      REG_MAX_DIFF: tol_w = val[WIDTH_W-1:0];
      REG_DELAY: lag_um = val;
      REG_ENABLE: begin
        if (ticks_on && !val[0]) flush_queue();
        ticks_on = val[0];
      end
      default: ;
    endcase
  endfunction

  function automatic out_item_t report(logic [FLOW_W-1:0] flow, cause_e c);
    out_item_t r;
    r.flow_percent = flow;
    r.cause = c;
    r.queue_overflow = dropped_push;
    dropped_push = 1'b0;
    return r;
  endfunction

  function automatic bit compensate(input in_item_t it, output out_item_t res);
    longint p, tgt, num, den, q;
    int newest, w, lo, hi;
    bit push;
    res = '0;
    if (it.action == ACT_SAMPLE) begin
      width_now = WIDTH_W'((longint'(it.adc_code) * FULL_SCALE + ADC_FULL / 2) / ADC_FULL);
      return 1'b0;
    end
    if (it.action == ACT_CLEAR) begin
      flush_queue();
      res = report(NEUTRAL_FLOW, CAUSE_CLEARED);
      return 1'b1;
    end
    if (it.action != ACT_TICK || !ticks_on) return 1'b0;

    p = longint'($signed(it.extruder_position));
    tgt = p + longint'(lag_um);
    push = (fill == 0);
    if (!push) begin
      newest = (wr_ptr == 0) ? QDEPTH - 1 : wr_ptr - 1;
      push = tgt >= slot_pos[newest] + INTERVAL_UM;
    end
    if (push) begin
      if (fill >= QDEPTH) begin
        dropped_push = 1'b1;
      end else begin
        slot_pos[wr_ptr] = tgt;
        slot_width[wr_ptr] = int'(width_now);
        wr_ptr = (wr_ptr + 1) % QDEPTH;
        fill++;
      end
    end

    if (width_now > NO_FIL_LIMIT) begin
      if (fill == 0 || slot_pos[rd_ptr] > p) return 1'b0;
      w = slot_width[rd_ptr];
      rd_ptr = (rd_ptr + 1) % QDEPTH;
      fill--;
      lo = int'(nom_w) - int'(tol_w);
      hi = int'(nom_w) + int'(tol_w);
      if (w != 0 && w >= lo && w <= hi) begin
        num = longint'(nom_w) * longint'(nom_w) * FLOW_SCALE;
        den = longint'(w) * longint'(w);
        q = (num + den / 2) / den;
        if (q > FLOW_MAX) q = FLOW_MAX;
        res = report(FLOW_W'(q), CAUSE_MEASURED);
      end else begin
        res = report(NEUTRAL_FLOW, CAUSE_RANGE);
      end
      return 1'b1;
    end
    flush_queue();
    res = report(NEUTRAL_FLOW, CAUSE_NO_FIL);
    return 1'b1;
  endfunction

  function automatic in_item_t mk_item(logic [1:0] act, logic [11:0] code, logic [POS_W-1:0] pos);
    in_item_t it;
    it.action = act;
    it.adc_code = code;
    it.extruder_position = pos;
    return it;
  endfunction

  function automatic void plan(in_item_t it);
    step_t s;
    s.item = it;
    s.fixed = 1'b0;
    s.fixed_res = '0;
    directed.push_back(s);
  endfunction

  function automatic void plan_fixed(in_item_t it, logic [FLOW_W-1:0] flow, cause_e c);
    step_t s;
    s.item = it;
    s.fixed = 1'b1;
    s.fixed_res.flow_percent = flow;
    s.fixed_res.cause = c;
    s.fixed_res.queue_overflow = 1'b0;
    directed.push_back(s);
  endfunction

  function automatic in_item_t gen_item();
    in_item_t it;
    int r, tw;
    it.action = ACT_TICK;
    it.adc_code = 12'($urandom);
    it.extruder_position = POS_W'({$urandom, $urandom});
    r = $urandom_range(99);
    if (r < (orderly ? 20 : 30)) begin
      it.action = ACT_SAMPLE;
      if (orderly || $urandom_range(9) < 6) begin
        tw = int'(nom_w) - int'(tol_w) - 3 + int'($urandom_range(0, 2 * int'(tol_w) + 6));
        if (tw < 0) tw = 0;
        if (orderly && tw <= int'(NO_FIL_LIMIT)) tw = int'(NO_FIL_LIMIT) + 1;
        if (tw > FULL_SCALE) tw = FULL_SCALE;
        it.adc_code = 12'((tw * ADC_FULL + FULL_SCALE / 2) / FULL_SCALE);
      end else if ($urandom_range(1) == 1) begin
        it.adc_code = 12'($urandom_range(0, 409));
      end
    end else if (orderly || r < 85) begin
      cur_pos += $urandom_range(step_lo, step_hi);
      it.extruder_position = cur_pos[POS_W-1:0];
    end else if (r < 91) begin
      it.action = ACT_CLEAR;
    end else if (r >= 96) begin
      it.action = ACT_UNUSED;
    end
    return it;
  endfunction

  task automatic send(input in_item_t it, input bit fixed, input out_item_t fixed_res);
    out_item_t res;
    bit made;
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    made = compensate(it, res);
    if (fixed) pending_flows.push_back(fixed_res);
    else if (made) pending_flows.push_back(res);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_flows.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_regs(input logic [WIDTH_W-1:0] nom, input logic [WIDTH_W-1:0] tol,
                          input logic [DELAY_W-1:0] lag, input logic on);
    logic [CFG_DATA_W-1:0] vals[4];
    logic [CFG_IDX_W-1:0] idxs[4];
    vals = '{CFG_DATA_W'(nom), CFG_DATA_W'(tol), CFG_DATA_W'(lag), CFG_DATA_W'(on)};
    idxs = '{REG_NOMINAL, REG_MAX_DIFF, REG_DELAY, REG_ENABLE};
    for (int k = 0; k < 4; k++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= idxs[k];
      cfg_wdata_i <= vals[k];
      @(negedge clk_i);
      apply_reg(idxs[k], vals[k]);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic void check_field(string name, longint exp_val, longint act_val);
    if (exp_val != act_val) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
    end
  endfunction

  // The receiver follows the random idle pattern, stays ready in steady phases, or sits out a long hold-off.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_flows.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected transfer, expected none actual flow %0d cause %0d overflow %0d",
                   $time, out_data_o.flow_percent, out_data_o.cause, out_data_o.queue_overflow);
      end else begin
        want = pending_flows.pop_front();
        check_field("flow_percent", want.flow_percent, out_data_o.flow_percent);
        check_field("cause", want.cause, out_data_o.cause);
        check_field("queue_overflow", want.queue_overflow, out_data_o.queue_overflow);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("filament_width_flow_compensator_core_tb: errors");
      $finish;
    end
  end

  initial begin
    nom_w = NOMINAL_RESET;
    tol_w = '0;
    lag_um = '0;
    ticks_on = 1'b1;
    width_now = '0;
    dropped_push = 1'b0;
    flush_queue();
    cur_pos = $urandom_range(0, 1000000);
    step_lo = 0;
    step_hi = 15000;

    plan_fixed(mk_item(ACT_TICK, 12'd0, 40'd0), NEUTRAL_FLOW, CAUSE_NO_FIL);
    plan_fixed(mk_item(ACT_CLEAR, 12'hFFF, 40'd0), NEUTRAL_FLOW, CAUSE_CLEARED);
    plan(mk_item(ACT_SAMPLE, 12'hFFF, 40'd0));
    plan_fixed(mk_item(ACT_TICK, 12'd0, 40'd5), NEUTRAL_FLOW, CAUSE_RANGE);
    plan(mk_item(ACT_SAMPLE, 12'd0, 40'd0));
    plan(mk_item(ACT_SAMPLE, 12'd2048, 40'd0));
    plan(mk_item(ACT_SAMPLE, 12'd819, 40'd0));
    plan_fixed(mk_item(ACT_TICK, 12'd0, 40'h7F_FFFF_FFFF), NEUTRAL_FLOW, CAUSE_MEASURED);
    plan_fixed(mk_item(ACT_TICK, 12'd0, 40'h80_0000_0000), NEUTRAL_FLOW, CAUSE_MEASURED);
    plan(mk_item(ACT_UNUSED, 12'hFFF, 40'hFF_FFFF_FFFF));
    plan(mk_item(ACT_TICK, 12'd0, 40'd0));
    plan(mk_item(ACT_SAMPLE, 12'd1, 40'd0));
    plan_fixed(mk_item(ACT_TICK, 12'd0, 40'd20000), NEUTRAL_FLOW, CAUSE_NO_FIL);
    plan(mk_item(ACT_SAMPLE, 12'd4094, 40'd0));
    plan(mk_item(ACT_SAMPLE, 12'h555, 40'd0));
    plan(mk_item(ACT_SAMPLE, 12'hAAA, 40'd0));
    plan(mk_item(ACT_TICK, 12'd0, 40'h55_5555_5555));
    plan(mk_item(ACT_TICK, 12'd0, 40'hAA_AAAA_AAAA));
    plan_fixed(mk_item(ACT_CLEAR, 12'd0, 40'd0), NEUTRAL_FLOW, CAUSE_CLEARED);

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    foreach (directed[k]) send(directed[k].item, directed[k].fixed, directed[k].fixed_res);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_regs(9'd1, 9'd0, 32'd0, 1'b1);
        1: set_regs(9'd500, 9'd500, 32'hFFFF_FFFF, 1'b1);
        3, 8: set_regs(9'($urandom_range(60, 400)), 9'($urandom_range(0, 80)),
                       32'($urandom_range(0, 200000)), 1'b0);
        6: set_regs(9'($urandom_range(60, 400)), 9'($urandom_range(0, 80)),
                    32'd1000000, 1'b1);
        default: set_regs(9'($urandom_range(60, 400)), 9'($urandom_range(0, 80)),
                          32'($urandom_range(0, 200000)), 1'b1);
      endcase
      orderly = (ph == 1 || ph == 6);
      step_lo = orderly ? 10000 : 0;
      step_hi = orderly ? 12000 : 15000;
      steady = (ph == 5);
      if (ph == 2) hold_req = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (ph == 7 && k == ITEMS_PER_PHASE / 2) settle();
        send(gen_item(), 1'b0, '0);
      end
      settle();
    end
    steady = 1'b0;
    orderly = 1'b0;

    if (errors == 0) $display("filament_width_flow_compensator_core_tb: clean");
    else $display("filament_width_flow_compensator_core_tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fwfc_pkg.sv
rtl/fwfc_ram.sv
rtl/fwfc_div.sv
rtl/filament_width_flow_compensator.sv
dv/filament_width_flow_compensator_core_tb.sv
